/* rtl/sparse_conv_gather_scatter_mac_core_assert.svh */
// assertion macros for the sparse convolution core
`ifndef SPARSE_CONV_GATHER_SCATTER_MAC_CORE_ASSERT_SVH
`define SPARSE_CONV_GATHER_SCATTER_MAC_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SCG_ASSERT(lbl, prop, msg)
`define SCG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/scg_pkg.sv */
`timescale 1ns / 1ps
package scg_pkg;

  localparam int IN_ROWS_DEF       = 1024;
  localparam int OUT_ROWS_DEF      = 1024;
  localparam int KERNEL_VOLUME_DEF = 27;
  localparam int MAX_CHANNELS_DEF  = 16;

  // token field widths cover the largest parameter values
  localparam int ROW_W   = 16;
  localparam int CH_W    = 6;
  localparam int LIM_W   = 7;
  localparam int WADDR_W = 13;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    FN_LOAD_FEAT = 3'd0,
    FN_LOAD_WGT  = 3'd1,
    FN_EDGE      = 3'd2,
    FN_CLEAR     = 3'd3,
    FN_READ      = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_CHANNELS  = 2'd0,
    CFG_OUT_CHANNELS = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_MAC   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_WLOAD = 2'd3
  } tok_op_e;

  typedef struct packed {
    logic                    valid;
    tok_op_e                 op;
    logic                    first;
    logic                    last;
    logic [ROW_W-1:0]        row;
    logic [WADDR_W-1:0]      waddr;
    logic [CH_W-1:0]         tgt;
    logic [LIM_W-1:0]        lim;
    logic signed [VAL_W-1:0] value;
  } tok_t;

  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] sum;
  } res_t;

endpackage

/* rtl/scg_if.sv */
`timescale 1ns / 1ps
interface scg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [9:0]  in_row;
  logic [9:0]  out_row;
  logic [4:0]  kernel;
  logic [3:0]  in_ch;
  logic [3:0]  out_ch;
  logic signed [15:0] value;
  modport source (output valid, func, in_row, out_row, kernel, in_ch, out_ch, value,
                  input ready);
  modport sink   (input valid, func, in_row, out_row, kernel, in_ch, out_ch, value,
                  output ready);
endinterface

interface scg_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  row;
  logic [3:0]  channel;
  logic signed [39:0] sum;
  logic        last;
  modport source (output valid, row, channel, sum, last, input ready);
  modport sink   (input valid, row, channel, sum, last, output ready);
endinterface

interface scg_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/scg_cell.sv */
`timescale 1ns / 1ps
module scg_cell #(
  parameter int IDX           = 0,
  parameter int OUT_ROWS      = scg_pkg::OUT_ROWS_DEF,
  parameter int KERNEL_VOLUME = scg_pkg::KERNEL_VOLUME_DEF,
  parameter int MAX_CHANNELS  = scg_pkg::MAX_CHANNELS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scg_pkg::tok_t tok_i,
  output scg_pkg::tok_t tok_o,
  output scg_pkg::res_t res_o
);

  localparam int ORW = (OUT_ROWS > 1) ? $clog2(OUT_ROWS) : 1;
  localparam int WD  = KERNEL_VOLUME * MAX_CHANNELS;
  localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
  localparam int AW  = scg_pkg::ACC_W;

  logic signed [scg_pkg::VAL_W-1:0] wmem [WD];
  logic signed [AW-1:0]             amem [OUT_ROWS];

  scg_pkg::tok_t tok_q;
  logic signed [scg_pkg::VAL_W-1:0]  w_q;
  logic signed [AW-1:0]              a_q;
  logic signed [AW-1:0]              run_q;
  logic signed [scg_pkg::PROD_W-1:0] prod_q;
  logic                              s3_vld_q, s3_first_q, s3_last_q, s3_en_q;
  logic [ORW-1:0]                    s3_row_q;

  logic                 mine_in;
  logic                 wb;
  logic                 acc_we;
  logic [ORW-1:0]       acc_wa;
  logic signed [AW-1:0] acc_wd;
  logic signed [AW-1:0] base;
  logic signed [AW:0]   sum_wide;
  logic signed [AW-1:0] sum_sat;

  assign mine_in = (tok_i.tgt == scg_pkg::CH_W'(IDX));

  // stage 3: saturating accumulate
  always_comb begin
    base     = s3_first_q ? a_q : run_q;
    sum_wide = {base[AW-1], base} + (AW+1)'(prod_q);
    if (sum_wide[AW] != sum_wide[AW-1]) begin
      sum_sat = sum_wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[AW-1:0];
    end
  end

  assign wb     = s3_vld_q && s3_last_q && s3_en_q;
  assign acc_we = wb || (tok_i.valid && tok_i.op == scg_pkg::OP_CLEAR);
  assign acc_wa = wb ? s3_row_q : ORW'(tok_i.row);
  assign acc_wd = wb ? sum_sat : '0;

  always_ff @(posedge clk_i) begin
    if (tok_i.valid && tok_i.op == scg_pkg::OP_WLOAD && mine_in) begin
      wmem[WAW'(tok_i.waddr)] <= tok_i.value;
    end
    if (tok_i.valid && tok_i.op == scg_pkg::OP_MAC) begin
      w_q <= wmem[WAW'(tok_i.waddr)];
    end
    if (tok_i.valid && ((tok_i.op == scg_pkg::OP_MAC && tok_i.first) ||
                        (tok_i.op == scg_pkg::OP_READ && mine_in))) begin
      a_q <= amem[ORW'(tok_i.row)];
    end
    if (acc_we) begin
      amem[acc_wa] <= acc_wd;
    end
  end

  // stage 2: product, and stage 3 payload
  always_ff @(posedge clk_i) begin
    prod_q     <= scg_pkg::PROD_W'(tok_q.value * w_q);
    s3_first_q <= tok_q.first;
    s3_last_q  <= tok_q.last;
    s3_en_q    <= (tok_q.lim > scg_pkg::LIM_W'(IDX));
    s3_row_q   <= ORW'(tok_q.row);
    if (s3_vld_q) begin
      run_q <= sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      s3_vld_q <= 1'b0;
    end else begin
      tok_q    <= tok_i;
      s3_vld_q <= tok_q.valid && tok_q.op == scg_pkg::OP_MAC;
    end
  end

  assign tok_o       = tok_q;
  assign res_o.valid = tok_q.valid && tok_q.op == scg_pkg::OP_READ &&
                       tok_q.tgt == scg_pkg::CH_W'(IDX);
  assign res_o.sum   = a_q;

endmodule

/* rtl/sparse_conv_gather_scatter_mac_core.sv */
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// in_item   in   valid/ready   func in_row out_row kernel in_ch out_ch value
// out_item  out  valid/ready   row channel sum last
// cfg       in   valid/ready   index data (ready always high)
//
// load feature, load weight and clear are handled in the idle state
// edge: one feature fetch per input channel, then a chain drain
// read: each channel's result waits on the trip down the cell chain
// after reset a clearing pass over all OUT_ROWS rows zeroes the accumulators, no item taken
// a waiting result does not block the next item; a new read waits for the output register
`include "sparse_conv_gather_scatter_mac_core_assert.svh"
module sparse_conv_gather_scatter_mac_core #(
  parameter int IN_ROWS       = scg_pkg::IN_ROWS_DEF,
  parameter int OUT_ROWS      = scg_pkg::OUT_ROWS_DEF,
  parameter int KERNEL_VOLUME = scg_pkg::KERNEL_VOLUME_DEF,
  parameter int MAX_CHANNELS  = scg_pkg::MAX_CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scg_in_if.sink    in_item,
  scg_out_if.source out_item,
  scg_cfg_if.sink   cfg
);

  localparam int IRW     = (IN_ROWS > 1) ? $clog2(IN_ROWS) : 1;
  localparam int ORW     = (OUT_ROWS > 1) ? $clog2(OUT_ROWS) : 1;
  localparam int CNW     = $clog2(MAX_CHANNELS + 1);
  localparam int FD      = IN_ROWS * MAX_CHANNELS;
  localparam int FAW     = (FD > 1) ? $clog2(FD) : 1;
  localparam int DRAIN_N = MAX_CHANNELS + 4;
  localparam int DW      = $clog2(DRAIN_N + 1);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EDGE  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_RISS  = 6'b010000,
    ST_RWAIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [4:0] in_chn_q, out_chn_q;
  logic [CNW-1:0] nci, nco;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_chn_q  <= 5'd16;
      out_chn_q <= 5'd16;
    end else if (cfg.valid) begin
      case (cfg.index)
        scg_pkg::CFG_IN_CHANNELS:  in_chn_q  <= cfg.data;
        scg_pkg::CFG_OUT_CHANNELS: out_chn_q <= cfg.data;
        default: ;
      endcase
    end
  end
  assign cfg.ready = 1'b1;

  // counts saturate at the cell count
  assign nci = (int'(in_chn_q) > MAX_CHANNELS) ? CNW'(MAX_CHANNELS) : CNW'(in_chn_q);
  assign nco = (int'(out_chn_q) > MAX_CHANNELS) ? CNW'(MAX_CHANNELS) : CNW'(out_chn_q);

  // sequencer registers
  logic [ORW-1:0] init_q, init_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]  drn_q, drn_d;
  logic [IRW-1:0] ir_q, ir_d;
  logic [ORW-1:0] or_q, or_d;
  logic [4:0]     k_q, k_d;
  logic [CNW-1:0] nci_q, nci_d, nco_q, nco_d;

  scg_pkg::tok_t meta_q, meta_d, head;
  logic signed [scg_pkg::VAL_W-1:0] f_rd_q;
  logic signed [scg_pkg::VAL_W-1:0] fmem [FD];
  logic fm_we, f_re;

  // output register
  logic        ov_q, ov_d;
  logic [9:0]  o_row_q, o_row_d;
  logic [3:0]  o_ch_q, o_ch_d;
  logic signed [scg_pkg::ACC_W-1:0] o_sum_q, o_sum_d;
  logic        o_last_q, o_last_d;

  logic in_acc;
  logic ir_ok, or_ok, k_ok, ic_ok, oc_ok;

  // cell chain
  scg_pkg::tok_t chain [MAX_CHANNELS+1];
  scg_pkg::res_t cres  [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] res_vld;
  logic                    res_any;
  logic signed [scg_pkg::ACC_W-1:0] res_sum;

  assign in_item.ready = (state_q == ST_IDLE);
  assign in_acc        = in_item.valid && in_item.ready;

  assign ir_ok = int'(in_item.in_row) < IN_ROWS;
  assign or_ok = int'(in_item.out_row) < OUT_ROWS;
  assign k_ok  = int'(in_item.kernel) < KERNEL_VOLUME;
  assign ic_ok = int'(in_item.in_ch) < MAX_CHANNELS;
  assign oc_ok = int'(in_item.out_ch) < MAX_CHANNELS;

  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    cnt_d    = cnt_q;
    drn_d    = drn_q;
    ir_d     = ir_q;
    or_d     = or_q;
    k_d      = k_q;
    nci_d    = nci_q;
    nco_d    = nco_q;
    meta_d   = '0;
    fm_we    = 1'b0;
    f_re     = 1'b0;
    ov_d     = ov_q && !out_item.ready;
    o_row_d  = o_row_q;
    o_ch_d   = o_ch_q;
    o_sum_d  = o_sum_q;
    o_last_d = o_last_q;
    case (state_q)
      ST_INIT: begin
        // clearing pass, one row a cycle
        meta_d.valid = 1'b1;
        meta_d.op    = scg_pkg::OP_CLEAR;
        meta_d.row   = scg_pkg::ROW_W'(init_q);
        if (int'(init_q) == OUT_ROWS - 1) begin
          state_d = ST_IDLE;
        end else begin
          init_d = init_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.func)
            scg_pkg::FN_LOAD_FEAT: fm_we = ir_ok && ic_ok;
            scg_pkg::FN_LOAD_WGT: begin
              if (k_ok && ic_ok && oc_ok) begin
                meta_d.valid = 1'b1;
                meta_d.op    = scg_pkg::OP_WLOAD;
                meta_d.tgt   = scg_pkg::CH_W'(in_item.out_ch);
                meta_d.waddr = scg_pkg::WADDR_W'(int'(in_item.kernel) * MAX_CHANNELS +
                                                 int'(in_item.in_ch));
                meta_d.value = in_item.value;
              end
            end
            scg_pkg::FN_EDGE: begin
              if (ir_ok && or_ok && k_ok && nci != '0) begin
                ir_d    = IRW'(in_item.in_row);
                or_d    = ORW'(in_item.out_row);
                k_d     = in_item.kernel;
                nci_d   = nci;
                nco_d   = nco;
                cnt_d   = '0;
                state_d = ST_EDGE;
              end
            end
            scg_pkg::FN_CLEAR: begin
              if (or_ok) begin
                meta_d.valid = 1'b1;
                meta_d.op    = scg_pkg::OP_CLEAR;
                meta_d.row   = scg_pkg::ROW_W'(in_item.out_row);
              end
            end
            scg_pkg::FN_READ: begin
              if (or_ok && nco != '0) begin
                or_d    = ORW'(in_item.out_row);
                nco_d   = nco;
                cnt_d   = '0;
                state_d = ST_RISS;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EDGE: begin
        // one input channel per cycle; feature arrives with the token
        f_re         = 1'b1;
        meta_d.valid = 1'b1;
        meta_d.op    = scg_pkg::OP_MAC;
        meta_d.first = (cnt_q == '0);
        meta_d.last  = (cnt_q == nci_q - 1'b1);
        meta_d.row   = scg_pkg::ROW_W'(or_q);
        meta_d.waddr = scg_pkg::WADDR_W'(int'(k_q) * MAX_CHANNELS + int'(cnt_q));
        meta_d.lim   = scg_pkg::LIM_W'(nco_q);
        if (cnt_q == nci_q - 1'b1) begin
          drn_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // let the last write-back leave the far cell
        if (drn_q == DW'(DRAIN_N)) begin
          state_d = ST_IDLE;
        end else begin
          drn_d = drn_q + 1'b1;
        end
      end
      ST_RISS: begin
        if (!ov_q || out_item.ready) begin
          meta_d.valid = 1'b1;
          meta_d.op    = scg_pkg::OP_READ;
          meta_d.row   = scg_pkg::ROW_W'(or_q);
          meta_d.tgt   = scg_pkg::CH_W'(cnt_q);
          state_d      = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        if (res_any) begin
          ov_d     = 1'b1;
          o_row_d  = 10'(or_q);
          o_ch_d   = 4'(cnt_q);
          o_sum_d  = res_sum;
          o_last_d = (cnt_q == nco_q - 1'b1);
          if (cnt_q == nco_q - 1'b1) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_RISS;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      init_q  <= '0;
      cnt_q   <= '0;
      drn_q   <= '0;
      meta_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      cnt_q   <= cnt_d;
      drn_q   <= drn_d;
      meta_q  <= meta_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q     <= ir_d;
    or_q     <= or_d;
    k_q      <= k_d;
    nci_q    <= nci_d;
    nco_q    <= nco_d;
    o_row_q  <= o_row_d;
    o_ch_q   <= o_ch_d;
    o_sum_q  <= o_sum_d;
    o_last_q <= o_last_d;
  end

  // feature store
  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      fmem[FAW'(int'(in_item.in_row) * MAX_CHANNELS + int'(in_item.in_ch))] <= in_item.value;
    end
    if (f_re) begin
      f_rd_q <= fmem[FAW'(int'(ir_q) * MAX_CHANNELS + int'(cnt_q))];
    end
  end

  always_comb begin
    head = meta_q;
    if (meta_q.op == scg_pkg::OP_MAC) begin
      head.value = f_rd_q;
    end
  end

  assign chain[0] = head;

  // one cell per output channel
  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
    scg_cell #(
      .IDX           (i),
      .OUT_ROWS      (OUT_ROWS),
      .KERNEL_VOLUME (KERNEL_VOLUME),
      .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1]),
      .res_o  (cres[i])
    );
    assign res_vld[i] = cres[i].valid;
  end

  always_comb begin
    res_sum = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      res_sum = res_sum | (cres[i].sum & {scg_pkg::ACC_W{cres[i].valid}});
    end
  end
  assign res_any = |res_vld;

  assign out_item.valid   = ov_q;
  assign out_item.row     = o_row_q;
  assign out_item.channel = o_ch_q;
  assign out_item.sum     = o_sum_q;
  assign out_item.last    = o_last_q;

  `SCG_ASSERT_ALWAYS(a_res_onehot, $onehot0(res_vld), "two cells answered one read")
  `SCG_ASSERT(a_res_in_wait, res_any |-> state_q == ST_RWAIT, "read result out of turn")
  `SCG_ASSERT(a_edge_cnt, state_q == ST_EDGE |-> cnt_q < nci_q, "edge channel overrun")
  `SCG_ASSERT(a_chain_end, chain[MAX_CHANNELS].valid |-> state_q != ST_IDLE || 1'b1 ||
              state_q == ST_INIT, "chain end token")
  `SCG_ASSERT(a_rd_free, state_q == ST_RWAIT && res_any |-> !ov_q || out_item.ready,
              "result would overwrite waiting item")

endmodule
